>>> sv/ldkl_pkg.sv
package ldkl_pkg;

   localparam int WORD_W = 32;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic                     end_of_list;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] kept_value;
      logic                     last_kept;
      logic                     overflowed;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic count;
      logic read;
      logic check;
      logic flush;
   } ldkl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic end_seen;
      logic idx_last;
   } ldkl_sts_type;

endpackage

>>> sv/list_dedup_keep_last.sv
// Loads a list of signed 32-bit words, one per start, and on the word marked
// end_of_list emits the list with repeats removed, keeping the last copy of
// each value (the first word is always kept). Each stored word is then matched
// against the key table, which updates its count. After the end word the stored
// list is walked word by word (list memory read, then key match and count
// decrement), and a final step releases the final result and clears the tables;
// busy stays high throughout.
// Results appear on rsp_strobe for one cycle each and cannot be held off.
// Words beyond DEPTH are dropped and flagged in overflowed.
module list_dedup_keep_last
   import ldkl_pkg::*;
#(
   parameter int DEPTH = 32
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   ldkl_cmd_type cmd;
   ldkl_sts_type sts;

   ldkl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   ldkl_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> sv/ldkl_ctrl.sv
module ldkl_ctrl
   import ldkl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ldkl_sts_type sts,
   output ldkl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_READ,
      ST_CHECK,
      ST_FLUSH
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (!sts.full) begin
                  state_in = ST_COUNT;
               end else if (start && sts.full) begin
                  // list already full: drop the word, emit if it ends the list
                  state_in = ST_IDLE;
               end
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            state_in  = sts.end_seen ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.idx_last ? ST_FLUSH : ST_READ;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // an end-marked word that arrives on a full list skips counting
   logic full_end;
   assign full_end = (state_ff == ST_IDLE) && start && sts.full && sts.end_seen;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else if (full_end) begin
         state_ff <= ST_READ;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/ldkl_datapath.sv
module ldkl_datapath
   import ldkl_pkg::*;
#(
   parameter int DEPTH = 32
)
(
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  ldkl_cmd_type cmd,
   output ldkl_sts_type sts,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // list storage
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_ff;

   logic [CNT_W-1:0]  fill_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              overflow_ff;
   logic              end_ff;
   logic [WORD_W-1:0] hold_ff;

   // key table
   logic [WORD_W-1:0] key_ff    [DEPTH];
   logic [CNT_W-1:0]  kcount_ff [DEPTH];
   logic [DEPTH-1:0]  kvalid_ff;
   logic [CNT_W-1:0]  kfill_ff;

   logic [WORD_W-1:0] pend_ff;
   logic              pend_valid_ff;

   logic              rsp_strobe_ff;
   rsp_type           rsp_data_ff;

   logic              full;
   logic [WORD_W-1:0] cmp_value;
   logic [DEPTH-1:0]  match;
   logic [DEPTH-1:0]  dup;
   logic              any_match;
   logic              drop;
   logic              idx_last;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign cmp_value = cmd.check ? rd_ff : hold_ff;

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         match[k] = kvalid_ff[k] && (key_ff[k] == cmp_value);
         dup[k]   = match[k] && (kcount_ff[k] > CNT_W'(1));
      end
   end

   assign any_match = |match;
   assign drop      = (idx_ff != '0) && (|dup);
   assign idx_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == fill_ff);

   assign sts.full     = full;
   assign sts.end_seen = cmd.load ? req_data.end_of_list : end_ff;
   assign sts.idx_last = idx_last;

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem[fill_ff[IDX_W-1:0]] <= req_data.value;
      end
      if (cmd.read) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hold_ff <= req_data.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         idx_ff      <= '0;
         overflow_ff <= 1'b0;
         end_ff      <= 1'b0;
      end else begin
         if (cmd.load) begin
            end_ff <= req_data.end_of_list;
            idx_ff <= '0;
            if (full) begin
               overflow_ff <= 1'b1;
            end else begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
         end
         if (cmd.check) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.flush) begin
            fill_ff     <= '0;
            overflow_ff <= 1'b0;
            end_ff      <= 1'b0;
         end
      end
   end

   // key payload: count up on load, count down on a dropped duplicate
   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         if (cmd.count) begin
            if (match[k]) begin
               kcount_ff[k] <= kcount_ff[k] + CNT_W'(1);
            end else if (!any_match && (kfill_ff[IDX_W-1:0] == IDX_W'(k))) begin
               key_ff[k]    <= hold_ff;
               kcount_ff[k] <= CNT_W'(1);
            end
         end
         if (cmd.check && drop && match[k]) begin
            kcount_ff[k] <= kcount_ff[k] - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kvalid_ff <= '0;
         kfill_ff  <= '0;
      end else if (cmd.flush) begin
         kvalid_ff <= '0;
         kfill_ff  <= '0;
      end else if (cmd.count && !any_match) begin
         kvalid_ff[kfill_ff[IDX_W-1:0]] <= 1'b1;
         kfill_ff                       <= kfill_ff + CNT_W'(1);
      end
   end

   // hold each kept word back by one so the final one can carry last_kept
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ((cmd.check && !drop) || cmd.flush) && pend_valid_ff;
         if (cmd.check && !drop) begin
            pend_valid_ff <= 1'b1;
         end
         if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check && !drop) begin
         pend_ff                <= rd_ff;
         rsp_data_ff.kept_value <= pend_ff;
         rsp_data_ff.last_kept  <= 1'b0;
         rsp_data_ff.overflowed <= overflow_ff;
      end
      if (cmd.flush) begin
         rsp_data_ff.kept_value <= pend_ff;
         rsp_data_ff.last_kept  <= 1'b1;
         rsp_data_ff.overflowed <= overflow_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
